### sv/umf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package umf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_RADIUS = 2;
    localparam int ROWS_KEPT  = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROWSEL_W   = $clog2(ROWS_KEPT);
    localparam int ADDR_W     = COL_W + ROWSEL_W;
    localparam int LIN_W      = 23;
    localparam int SUM_W      = 29;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMOUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAR    = 3'd5;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       frame_end;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADJUST,
        ST_CALC,
        ST_DECIDE,
        ST_TAPS,
        ST_ACCUM,
        ST_MULT,
        ST_FINISH,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic              load;
        logic              adjust;
        logic              calc;
        logic              decide;
        logic              issue;
        logic signed [2:0] dy;
        logic signed [2:0] dx;
        logic              mult;
        logic              finish;
    } t_ctl_cmd;

    typedef struct packed {
        logic       emit;
        logic [1:0] radius;
    } t_dp_status;

endpackage
`default_nettype wire

### sv/unsharp_mask_filter.sv
// unsharp mask filter, one transaction at a time
// push or drain without result: adjust, calc and decide states, then back to idle and ready
// result: after decide, one row store read per window tap, then accum, mult and finish; valid is held in send
// a new transaction is accepted only in idle, once the previous result has been taken
// synchronous active-low reset clears counters and loads register defaults; row store is not cleared
`timescale 1ns / 1ps
`default_nettype none
module unsharp_mask_filter
    import umf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_ctl_cmd   cmd;
    t_dp_status status;

    umf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    umf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

### sv/umf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module umf_ctrl
    import umf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_dp_status i_status,
    output t_ctl_cmd        o_cmd
);

    t_state            r_state, n_state;
    logic signed [2:0] r_dy, n_dy, r_dx, n_dx;
    logic signed [2:0] rad_s;
    logic              last_tap;

    assign rad_s    = $signed({1'b0, i_status.radius});
    assign last_tap = (r_dx == rad_s) && (r_dy == rad_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dy    <= '0;
            r_dx    <= '0;
        end else begin
            r_state <= n_state;
            r_dy    <= n_dy;
            r_dx    <= n_dx;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_ADJUST;
            ST_ADJUST: n_state = ST_CALC;
            ST_CALC:   n_state = ST_DECIDE;
            ST_DECIDE: n_state = i_status.emit ? ST_TAPS : ST_IDLE;
            ST_TAPS:   if (last_tap) n_state = ST_ACCUM;
            ST_ACCUM:  n_state = ST_MULT;
            ST_MULT:   n_state = ST_FINISH;
            ST_FINISH: n_state = ST_SEND;
            ST_SEND:   if (i_out_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // tap walk over the window, row by row
    always_comb begin
        n_dy = r_dy;
        n_dx = r_dx;
        case (r_state)
            ST_DECIDE: begin
                n_dy = -rad_s;
                n_dx = -rad_s;
            end
            ST_TAPS: begin
                if (r_dx == rad_s) begin
                    n_dx = -rad_s;
                    n_dy = r_dy + 3'sd1;
                end else begin
                    n_dx = r_dx + 3'sd1;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.dy    = r_dy;
        o_cmd.dx    = r_dx;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_ADJUST: o_cmd.adjust = 1'b1;
            ST_CALC:   o_cmd.calc = 1'b1;
            ST_DECIDE: o_cmd.decide = 1'b1;
            ST_TAPS:   o_cmd.issue = 1'b1;
            ST_MULT:   o_cmd.mult = 1'b1;
            ST_FINISH: o_cmd.finish = 1'b1;
            ST_SEND:   o_out_valid = 1'b1;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

### sv/umf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module umf_datapath
    import umf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_in_item              i_in_data,
    input  wire t_ctl_cmd              i_cmd,
    output t_dp_status                 o_status,
    output t_out_item                  o_out_data
);

    function automatic logic [7:0] clamp_px(input logic signed [44:0] t);
        logic [7:0] v;
        if (t < 0) v = 8'd0;
        else if (t[44:24] > 21'd255) v = 8'd255;
        else v = t[31:24];
        return v;
    endfunction

    logic [10:0] r_cfg_width;
    logic [12:0] r_cfg_height;
    logic [11:0] r_cfg_amount;
    logic [1:0]  r_cfg_radius;
    logic [47:0] r_cfg_near, r_cfg_far;

    logic [10:0] eff_w;
    logic [12:0] eff_h;
    logic [1:0]  eff_rad;

    t_in_item          r_item;
    logic [COL_W-1:0]  r_in_col, r_out_col;
    logic [11:0]       r_in_row, r_out_row;
    logic              r_in_done;
    logic [LIN_W-1:0]  r_pushed, r_pending, r_total;
    logic [11:0]       r_lag;

    logic [31:0]       mem [0:ROWS_KEPT*MAX_WIDTH-1];
    logic [31:0]       r_rd;
    logic [ADDR_W-1:0] waddr, raddr;
    logic              we;

    logic              r_acc_en, r_ctr_d;
    logic [15:0]       wt, r_wt_d;
    logic [SUM_W-1:0]  r_sum_r, r_sum_g, r_sum_b;
    logic [31:0]       r_centre;
    logic signed [43:0] r_prod_r, r_prod_g, r_prod_b;

    logic              col_wrap;
    logic [12:0]       row_t;
    logic signed [13:0] rr, cc;
    logic [11:0]       rr_c;
    logic [COL_W-1:0]  cc_c;
    logic [1:0]        ady, adx, lo, hi;
    logic              emit;
    logic [LIN_W-1:0]  pend_lag;

    assign eff_w   = (r_cfg_width == 11'd0) ? 11'd1 :
                     (r_cfg_width > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : r_cfg_width;
    assign eff_h   = (r_cfg_height == 13'd0) ? 13'd1 :
                     (r_cfg_height > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : r_cfg_height;
    assign eff_rad = (r_cfg_radius > 2'(MAX_RADIUS)) ? 2'(MAX_RADIUS) : r_cfg_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= 11'd640;
            r_cfg_height <= 13'd480;
            r_cfg_amount <= 12'd384;
            r_cfg_radius <= 2'd1;
            r_cfg_near   <= 48'd65535;
            r_cfg_far    <= 48'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:  r_cfg_width  <= i_cfg_data[10:0];
                REG_HEIGHT: r_cfg_height <= i_cfg_data[12:0];
                REG_AMOUNT: r_cfg_amount <= i_cfg_data[11:0];
                REG_RADIUS: r_cfg_radius <= i_cfg_data[1:0];
                REG_NEAR:   r_cfg_near   <= i_cfg_data;
                REG_FAR:    r_cfg_far    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input position fix-up before the write
    assign col_wrap = {1'b0, r_in_col} >= eff_w;
    always_comb begin
        row_t = col_wrap ? {1'b0, r_in_row} + 13'd1 : {1'b0, r_in_row};
        if (row_t >= eff_h) row_t = eff_h - 13'd1;
    end

    assign pend_lag = r_pending + LIN_W'(r_lag);
    always_comb begin
        if (r_item.operation == OP_DRAIN)
            emit = r_in_done && (r_pending < r_total);
        else
            emit = !r_in_done && (r_pending < r_total) && (r_pushed >= pend_lag);
    end
    assign o_status.emit   = emit;
    assign o_status.radius = eff_rad;

    assign we    = i_cmd.decide && (r_item.operation == OP_PUSH) && !r_in_done;
    assign waddr = {r_in_row[ROWSEL_W-1:0], r_in_col};

    // window tap address with edge replication
    always_comb begin
        rr = $signed({2'b00, r_out_row}) + 14'(i_cmd.dy);
        cc = $signed({4'b0000, r_out_col}) + 14'(i_cmd.dx);
        if (rr < 0) rr_c = 12'd0;
        else if (rr > $signed({1'b0, eff_h} - 14'sd1)) rr_c = 12'(eff_h - 13'd1);
        else rr_c = rr[11:0];
        if (cc < 0) cc_c = '0;
        else if (cc > $signed({3'b000, eff_w} - 14'sd1)) cc_c = COL_W'(eff_w - 11'd1);
        else cc_c = cc[COL_W-1:0];
    end
    assign raddr = {rr_c[ROWSEL_W-1:0], cc_c};

    assign ady = (i_cmd.dy < 0) ? 2'(-i_cmd.dy) : 2'(i_cmd.dy);
    assign adx = (i_cmd.dx < 0) ? 2'(-i_cmd.dx) : 2'(i_cmd.dx);
    assign lo  = (ady < adx) ? ady : adx;
    assign hi  = (ady < adx) ? adx : ady;
    always_comb begin
        case ({lo, hi})
            4'b0000: wt = r_cfg_near[15:0];
            4'b0001: wt = r_cfg_near[31:16];
            4'b0010: wt = r_cfg_near[47:32];
            4'b0101: wt = r_cfg_far[15:0];
            4'b0110: wt = r_cfg_far[31:16];
            4'b1010: wt = r_cfg_far[47:32];
            default: wt = 16'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= {r_item.alpha, r_item.blue, r_item.green, r_item.red};
        r_rd <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_in_done <= 1'b0;
            r_acc_en  <= 1'b0;
        end else begin
            r_acc_en <= i_cmd.issue;
            if (i_cmd.adjust && r_item.operation == OP_PUSH && !r_in_done) begin
                r_in_col <= col_wrap ? '0 : r_in_col;
                r_in_row <= row_t[11:0];
            end
            if (we) begin
                if ({1'b0, r_in_col} + 11'd1 >= eff_w) begin
                    r_in_col <= '0;
                    if ({1'b0, r_in_row} + 13'd1 >= eff_h) r_in_done <= 1'b1;
                    else r_in_row <= r_in_row + 12'd1;
                end else begin
                    r_in_col <= r_in_col + 1'b1;
                end
            end
            if (i_cmd.finish) begin
                if (r_pending + 1'b1 >= r_total) begin
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                    r_in_done <= 1'b0;
                end else if ({1'b0, r_out_col} + 11'd1 >= eff_w) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + 12'd1;
                end else begin
                    r_out_col <= r_out_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_in_data;
        if (i_cmd.calc) begin
            r_pushed  <= LIN_W'(r_in_row * eff_w) + LIN_W'(r_in_col);
            r_pending <= LIN_W'(r_out_row * eff_w) + LIN_W'(r_out_col);
            r_total   <= LIN_W'(eff_h * eff_w);
            r_lag     <= 12'(eff_rad * eff_w) + 12'(eff_rad);
        end
        r_wt_d  <= wt;
        r_ctr_d <= (i_cmd.dy == 3'sd0) && (i_cmd.dx == 3'sd0);
        if (i_cmd.decide) begin
            r_sum_r <= '0;
            r_sum_g <= '0;
            r_sum_b <= '0;
        end else if (r_acc_en) begin
            r_sum_r <= r_sum_r + SUM_W'(r_wt_d * r_rd[7:0]);
            r_sum_g <= r_sum_g + SUM_W'(r_wt_d * r_rd[15:8]);
            r_sum_b <= r_sum_b + SUM_W'(r_wt_d * r_rd[23:16]);
        end
        if (r_acc_en && r_ctr_d) r_centre <= r_rd;
        if (i_cmd.mult) begin
            r_prod_r <= $signed({1'b0, r_cfg_amount}) *
                        ($signed({7'd0, r_centre[7:0], 16'd0}) - $signed({2'b00, r_sum_r}));
            r_prod_g <= $signed({1'b0, r_cfg_amount}) *
                        ($signed({7'd0, r_centre[15:8], 16'd0}) - $signed({2'b00, r_sum_g}));
            r_prod_b <= $signed({1'b0, r_cfg_amount}) *
                        ($signed({7'd0, r_centre[23:16], 16'd0}) - $signed({2'b00, r_sum_b}));
        end
        if (i_cmd.finish) begin
            o_out_data.out_red   <= clamp_px($signed({13'd0, r_centre[7:0], 24'd0})
                                             + 45'(r_prod_r));
            o_out_data.out_green <= clamp_px($signed({13'd0, r_centre[15:8], 24'd0})
                                             + 45'(r_prod_g));
            o_out_data.out_blue  <= clamp_px($signed({13'd0, r_centre[23:16], 24'd0})
                                             + 45'(r_prod_b));
            o_out_data.out_alpha <= r_centre[31:24];
            o_out_data.frame_end <= (r_pending + 1'b1 >= r_total);
        end
    end

endmodule
`default_nettype wire
